>>> src/two_length_frame_deframer_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-length frame deframer
// Shared concurrent assertion forms, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef TWO_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define TWO_LENGTH_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Checked only outside reset.
`define TFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in every cycle, reset included.
`define TFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/tfd_pkg.sv
// ---------------------------------------------------------------------------
// tfd_pkg
// Types and constants shared by the two-length frame deframer modules.
// ---------------------------------------------------------------------------
package tfd_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int BYTE_W          = 8;
  localparam int HEADER_BYTES    = 8;
  localparam int LEN_FIELD_BYTES = 4;

  localparam logic [2:0] HDR_CNT_LAST = 3'(HEADER_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_META   = 2'd1,
    PH_BODY   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  localparam logic [1:0] PART_META  = 2'd0;
  localparam logic [1:0] PART_BODY  = 2'd1;
  localparam logic [1:0] PART_EMPTY = 2'd2;
  localparam logic [1:0] PART_BAD   = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic [1:0]        part;
    logic              last;
  } result_t;

endpackage

>>> src/tfd_parser.sv
// ---------------------------------------------------------------------------
// tfd_parser
// Frame state machine: collects the header, counts the payload and builds
// the result for each accepted byte.
// ---------------------------------------------------------------------------
module tfd_parser #(
  parameter int LENGTH_BITS = tfd_pkg::LENGTH_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [tfd_pkg::BYTE_W-1:0] in_byte,
  output tfd_pkg::result_t          res
);
  import tfd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_HDR  = LENGTH_BITS'(LEN_FIELD_BYTES);

  phase_t                 phase, phase_next;
  logic [2:0]             header_count, header_count_next;
  logic [LENGTH_BITS-1:0] total_length, total_length_next;
  logic [LENGTH_BITS-1:0] meta_length, meta_length_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;

  logic [LENGTH_BITS+BYTE_W-1:0] total_wide, meta_wide;
  logic [LENGTH_BITS-1:0]        total_shift, meta_shift, body_len;
  logic                          hdr_done, total_short, meta_bad;

  // Only the low LENGTH_BITS of each length field are kept.
  assign total_wide  = {total_length, in_byte};
  assign meta_wide   = {meta_length, in_byte};
  assign total_shift = total_wide[LENGTH_BITS-1:0];
  assign meta_shift  = meta_wide[LENGTH_BITS-1:0];
  assign hdr_done    = (header_count == HDR_CNT_LAST);
  assign total_short = (total_length < LEN_HDR);
  assign body_len    = total_length - LEN_HDR;
  assign meta_bad    = (meta_shift > body_len);

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    total_length_next = total_length;
    meta_length_next  = meta_length;
    bytes_left_next   = bytes_left;
    if (in_valid) begin
      case (phase)
        PH_HEADER: begin
          header_count_next = header_count + 3'd1;
          if (!header_count[2]) begin
            total_length_next = total_shift;
          end else begin
            meta_length_next = meta_shift;
          end
          if (hdr_done && !total_short) begin
            bytes_left_next = body_len;
            if (meta_bad) begin
              phase_next = (body_len != LEN_ZERO) ? PH_SKIP : PH_HEADER;
            end else if (body_len == LEN_ZERO) begin
              phase_next = PH_HEADER;
            end else begin
              phase_next = (meta_shift != LEN_ZERO) ? PH_META : PH_BODY;
            end
          end
        end
        PH_META: begin
          // An exhausted count here means the state is inconsistent; resync.
          if (bytes_left == LEN_ZERO || meta_length == LEN_ZERO) begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
          end else begin
            meta_length_next = meta_length - LEN_ONE;
            bytes_left_next  = bytes_left - LEN_ONE;
            if (bytes_left == LEN_ONE) begin
              phase_next = PH_HEADER;
            end else if (meta_length == LEN_ONE) begin
              phase_next = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (bytes_left == LEN_ZERO) begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
          end else begin
            bytes_left_next = bytes_left - LEN_ONE;
            if (bytes_left == LEN_ONE) begin
              phase_next = PH_HEADER;
            end
          end
        end
        PH_SKIP: begin
          if (bytes_left != LEN_ZERO) begin
            bytes_left_next = bytes_left - LEN_ONE;
          end
          if (bytes_left <= LEN_ONE) begin
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_comb begin
    res       = '0;
    res.valid = 1'b0;
    case (phase)
      PH_HEADER: begin
        if (hdr_done) begin
          res.valid = in_valid;
          res.last  = 1'b1;
          if (total_short || meta_bad) begin
            res.part = PART_BAD;
          end else if (body_len == LEN_ZERO) begin
            res.part = PART_EMPTY;
          end else begin
            res.valid = 1'b0;
          end
        end
      end
      PH_META: begin
        res.valid = in_valid && bytes_left != LEN_ZERO && meta_length != LEN_ZERO;
        res.data  = in_byte;
        res.part  = PART_META;
        res.last  = (bytes_left == LEN_ONE);
      end
      PH_BODY: begin
        res.valid = in_valid && bytes_left != LEN_ZERO;
        res.data  = in_byte;
        res.part  = PART_BODY;
        res.last  = (bytes_left == LEN_ONE);
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      total_length <= '0;
      meta_length  <= '0;
      bytes_left   <= '0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      total_length <= total_length_next;
      meta_length  <= meta_length_next;
      bytes_left   <= bytes_left_next;
    end
  end

endmodule

>>> src/two_length_frame_deframer_core.sv
// ---------------------------------------------------------------------------
// two_length_frame_deframer_core
// Splits a byte stream into header-part and body bytes of length-prefixed
// frames.
// ---------------------------------------------------------------------------
// One byte is taken per clock cycle while input ready is high: the frame
// counters update as each byte is accepted, and each result is registered
// in the result register, or in the skid register while the output stalls.
// This two-entry output stage keeps the input ready while one result waits
// on the output, so input ready drops only after a stall has lasted long
// enough to fill both entries. Frames start with an 8-byte header (big-endian
// total length, then big-endian header-part length); header bytes give no
// result except the single empty-frame or bad-frame result on the eighth byte.
module two_length_frame_deframer_core #(
  parameter int LENGTH_BITS = tfd_pkg::LENGTH_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [tfd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] in_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [tfd_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
  output logic [1:0]                 m_tuser,   // [1:0] part
  output logic                       m_tlast
);
  import tfd_pkg::*;

  result_t res;
  result_t out_q, skid_q;
  logic    in_fire, out_fire;

  assign s_tready = !skid_q.valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = out_q.valid && m_tready;

  tfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_fire),
    .in_byte (s_tdata),
    .res     (res)
  );

  // While the skid entry is full no byte is accepted, so only a drain occurs.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_q  <= '0;
      skid_q <= '0;
    end else if (skid_q.valid) begin
      if (out_fire) begin
        out_q        <= skid_q;
        skid_q.valid <= 1'b0;
      end
    end else if (!out_q.valid || out_fire) begin
      out_q <= res;
    end else if (res.valid) begin
      skid_q <= res;
    end
  end

  assign m_tvalid = out_q.valid;
  assign m_tdata  = out_q.data;
  assign m_tuser  = out_q.part;
  assign m_tlast  = out_q.last;

endmodule

>>> src/tfd_checker.sv
// ---------------------------------------------------------------------------
// tfd_checker
// Port-level checks for the two-length frame deframer, bound to the top.
// ---------------------------------------------------------------------------
`include "two_length_frame_deframer_core_assert.svh"

module tfd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [tfd_pkg::BYTE_W-1:0] m_tdata,
  input logic [1:0]                 m_tuser,
  input logic                       m_tlast
);
  import tfd_pkg::*;

  `TFD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output transaction dropped")
  `TFD_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output changed")
  `TFD_ASSERT(a_empty_form, m_tvalid && m_tuser == PART_EMPTY |-> m_tdata == '0 && m_tlast, "malformed empty-frame result")
  `TFD_ASSERT(a_bad_form, m_tvalid && m_tuser == PART_BAD |-> m_tdata == '0 && m_tlast, "malformed bad-frame result")
  `TFD_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind two_length_frame_deframer_core tfd_checker u_tfd_checker (.*);
